// File: src/pams_pkg.sv
// pams_pkg: shared widths, constants, codes, state and struct types for the
// period average speed meter. No dependencies.
package pams_pkg;

   // storage geometry
   localparam int PERIOD_SAMPLES = 8;
   localparam int MAX_TAPS       = 32;
   localparam int RING_AW        = $clog2(PERIOD_SAMPLES);
   localparam int FILL_W         = $clog2(PERIOD_SAMPLES + 1);
   localparam int TAP_AW         = $clog2(MAX_TAPS);
   localparam int KW             = $clog2(MAX_TAPS + 1);

   // field and register widths
   localparam int CLK_W      = 28;
   localparam int PPR_W      = 16;
   localparam int TAPS_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int HALF_W     = 31;
   localparam int COEF_IDX_W = 5;
   localparam int COEF_W     = 16;
   localparam int FREQ_W     = 37;
   localparam int RPM_W      = 43;
   localparam int FILT_W     = 48;
   localparam int AVG_W      = 4;

   // datapath widths
   localparam int PER_W  = HALF_W + 1;
   localparam int SUM_W  = PER_W + RING_AW;
   localparam int CN_W   = CLK_W + FILL_W;
   localparam int NUMF_W = CN_W + 10;
   localparam int NUM_W  = CN_W + 16;
   localparam int DEN_W  = SUM_W + PPR_W;
   localparam int PROD_W = COEF_W + RPM_W + 1;
   localparam int ACC_W  = PROD_W + TAP_AW;

   localparam int FREQ_SCALE = 1000;
   localparam int RPM_SCALE  = 60000;
   localparam int FRAC_BITS  = 15;
   localparam int ROUND_BIAS = 16384;

   // register reset values
   localparam logic [CLK_W-1:0]  CLOCK_HZ_RST = CLK_W'(125000000);
   localparam logic [PPR_W-1:0]  PPR_RST      = PPR_W'(20);
   localparam logic [TAPS_W-1:0] TAPS_RST     = TAPS_W'(1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PPR      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS     = 2'd2;

   // input function codes
   localparam logic FUNC_PERIOD = 1'b0;
   localparam logic FUNC_COEF   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RING_WR, ST_SUM, ST_SUM_END, ST_MUL_N, ST_MUL_F, ST_MUL_R,
      ST_MUL_D, ST_DIVF_GO, ST_DIVF_WAIT, ST_DIVR_GO, ST_DIVR_WAIT,
      ST_FIR_GO, ST_FIR_WAIT, ST_RESULT
   } meas_state_type;

   typedef enum logic [2:0] {
      FS_IDLE, FS_WRITE, FS_MAC, FS_DRAIN, FS_ROUND
   } fir_state_type;

   typedef struct packed {
      logic                         run;
      logic [RPM_W-1:0]             rpm;
      logic                         coef_wr;
      logic [COEF_IDX_W-1:0]        coef_index;
      logic signed [COEF_W-1:0]     coef_value;
   } fir_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: src/pams_ram.sv
// pams_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module pams_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/pams_div.sv
// pams_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on pams_pkg.
module pams_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pams_pkg::NUM_W-1:0]  num,
   input  logic [pams_pkg::DEN_W-1:0]  den,
   output pams_pkg::div_stat_type      stat,
   output logic [pams_pkg::NUM_W-1:0]  quot
);
   import pams_pkg::*;

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, q_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W);
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;
endmodule

// File: src/pams_fir.sv
// pams_fir: FIR filter over the rpm history, coefficient and delay line held
// in RAMs, one tap per cycle into a pipelined MAC. Depends on pams_pkg, pams_ram.
module pams_fir (
   input  logic                               clock,
   input  logic                               reset,
   input  pams_pkg::fir_req_type              req,
   input  logic [pams_pkg::TAPS_W-1:0]        taps,
   output logic                               done,
   output logic signed [pams_pkg::FILT_W-1:0] result
);
   import pams_pkg::*;

   fir_state_type state_ff, state_in;

   logic [TAP_AW-1:0]        ptr_ff, ptr_in;
   logic [KW-1:0]            k_ff, k_in;
   logic [KW-1:0]            ntaps;
   logic [MAX_TAPS-1:0]      cvalid_ff, cvalid_in;
   logic [MAX_TAPS-1:0]      dvalid_ff, dvalid_in;
   logic                     cv_ff, cv_in, dv_ff, dv_in;
   logic                     s1_ff, s1_in, s2_ff, s2_in;
   logic                     done_ff, done_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  rnd;
   logic [ACC_W-FILT_W:0]    top_bits;
   logic signed [FILT_W-1:0] res_ff, res_in;
   logic [TAP_AW-1:0]        rd_idx;
   logic                     dly_wr, rd_en;
   logic [COEF_W-1:0]        coef_q;
   logic [RPM_W-1:0]         dly_q;
   logic signed [COEF_W-1:0] coef_s;
   logic signed [RPM_W:0]    dly_s;

   assign ntaps  = ({1'b0, taps} > (TAPS_W+1)'(MAX_TAPS)) ? KW'(MAX_TAPS) : KW'(taps);
   assign rd_idx = ptr_ff - TAP_AW'(k_ff);

   pams_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (req.coef_wr),
      .wr_addr (TAP_AW'(req.coef_index)),
      .wr_data (req.coef_value),
      .rd_en   (rd_en),
      .rd_addr (TAP_AW'(k_ff)),
      .rd_data (coef_q)
   );

   pams_ram #(.WIDTH(RPM_W), .DEPTH(MAX_TAPS)) u_dly_ram (
      .clock   (clock),
      .wr_en   (dly_wr),
      .wr_addr (ptr_ff),
      .wr_data (req.rpm),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (dly_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE:  if (req.run) state_in = FS_WRITE;
         FS_WRITE: state_in = (ntaps == '0) ? FS_ROUND : FS_MAC;
         FS_MAC:   if (k_ff + 1'b1 == ntaps) state_in = FS_DRAIN;
         FS_DRAIN: if (!s1_ff && !s2_ff) state_in = FS_ROUND;
         FS_ROUND: state_in = FS_IDLE;
         default:  state_in = FS_IDLE;
      endcase
   end

   // strobes
   always_comb begin
      dly_wr  = (state_ff == FS_WRITE);
      rd_en   = (state_ff == FS_MAC);
      done_in = (state_ff == FS_ROUND);
   end

   // datapath; an entry never written reads as zero
   always_comb begin
      ptr_in    = ptr_ff;
      k_in      = k_ff;
      cvalid_in = cvalid_ff;
      dvalid_in = dvalid_ff;
      acc_in    = acc_ff;
      res_in    = res_ff;
      cv_in     = cvalid_ff[TAP_AW'(k_ff)];
      dv_in     = dvalid_ff[rd_idx];
      s1_in     = rd_en;
      s2_in     = s1_ff;
      coef_s    = cv_ff ? signed'(coef_q) : '0;
      dly_s     = dv_ff ? signed'({1'b0, dly_q}) : '0;
      prod_in   = PROD_W'(coef_s) * PROD_W'(dly_s);
      rnd       = acc_ff + ACC_W'(ROUND_BIAS);
      rnd       = rnd >>> FRAC_BITS;
      top_bits  = rnd[ACC_W-1:FILT_W-1];
      if (req.coef_wr) begin
         cvalid_in[TAP_AW'(req.coef_index)] = 1'b1;
      end
      case (state_ff)
         FS_WRITE: begin
            dvalid_in[ptr_ff] = 1'b1;
            k_in              = '0;
            acc_in            = '0;
         end
         FS_MAC: k_in = k_ff + 1'b1;
         FS_ROUND: begin
            if ((&top_bits) || (~|top_bits)) begin
               res_in = rnd[FILT_W-1:0];
            end else if (rnd[ACC_W-1]) begin
               res_in = {1'b1, {(FILT_W-1){1'b0}}};
            end else begin
               res_in = {1'b0, {(FILT_W-1){1'b1}}};
            end
            ptr_in = ptr_ff + 1'b1;
         end
         default: ;
      endcase
      if (s2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FS_IDLE;
         ptr_ff    <= '0;
         cvalid_ff <= '0;
         dvalid_ff <= '0;
         s1_ff     <= 1'b0;
         s2_ff     <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         cvalid_ff <= cvalid_in;
         dvalid_ff <= dvalid_in;
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      cv_ff   <= cv_in;
      dv_ff   <= dv_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

   a_mac_in_run: assert property (@(posedge clock) disable iff (reset)
      s2_ff |-> (state_ff == FS_MAC || state_ff == FS_DRAIN))
      else $error("MAC product outside a filter run");
   a_run_when_idle: assert property (@(posedge clock) disable iff (reset)
      req.run |-> state_ff == FS_IDLE)
      else $error("filter started while busy");
endmodule

// File: src/period_average_speed_meter.sv
// period_average_speed_meter: top level; ring of periods in RAM, averaging,
// reciprocal via shared divider, FIR. Depends on pams_pkg, pams_ram, pams_div, pams_fir.
//
//   channel | prefix | direction | transfers
//   input   | req_   | in        | period sample or coefficient write
//   result  | rsp_   | out       | frequency, raw rpm, filtered rpm, count
//   config  | csr_   | in        | register write, no read-back
//
// A coefficient write or zero period gives no result.
// After a period sample is accepted the input stalls while it is processed:
// the ring sum reads one RAM entry a cycle, the two divisions run in turn on
// the shared divider, and the filter does one tap a cycle. With pulses per
// rev zero the second division is skipped. Synchronous active-high reset; no
// clearing pass. A finished result sits in the output register while the next
// transaction is accepted; output back-pressure holds the block only once a
// second result is ready.
module period_average_speed_meter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [pams_pkg::HALF_W-1:0]         req_half_period_cycles,
   input  logic [pams_pkg::COEF_IDX_W-1:0]     req_coef_index,
   input  logic signed [pams_pkg::COEF_W-1:0]  req_coef_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pams_pkg::FREQ_W-1:0]         rsp_freq_millihertz,
   output logic [pams_pkg::RPM_W-1:0]          rsp_rpm_raw_milli,
   output logic signed [pams_pkg::FILT_W-1:0]  rsp_rpm_filtered_milli,
   output logic [pams_pkg::AVG_W-1:0]          rsp_samples_averaged,
   input  logic                                csr_write,
   input  logic [pams_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pams_pkg::CLK_W-1:0]          csr_data
);
   import pams_pkg::*;

   meas_state_type state_ff, state_in;

   logic [CLK_W-1:0]         clk_ff, clk_in;
   logic [PPR_W-1:0]         ppr_ff, ppr_in;
   logic [TAPS_W-1:0]        taps_ff, taps_in;
   logic [RING_AW-1:0]       head_ff, head_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [FILL_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [HALF_W-1:0]        half_ff, half_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [CN_W-1:0]          cn_ff, cn_in;
   logic [NUMF_W-1:0]        numf_ff, numf_in;
   logic [NUM_W-1:0]         numr_ff, numr_in;
   logic [DEN_W-1:0]         denr_ff, denr_in;
   logic [FREQ_W-1:0]        freq_ff, freq_in;
   logic [RPM_W-1:0]         rpm_ff, rpm_in;
   logic signed [FILT_W-1:0] filt_ff, filt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0]        rsp_freq_ff;
   logic [RPM_W-1:0]         rsp_rpm_ff;
   logic signed [FILT_W-1:0] rsp_filt_ff;
   logic [AVG_W-1:0]         rsp_avg_ff;

   logic                     accept, ring_wr, ring_rd, rsp_load;
   logic                     div_start;
   logic [NUM_W-1:0]         div_num, div_quot;
   logic [DEN_W-1:0]         div_den;
   div_stat_type             div_stat;
   fir_req_type              fir_req;
   logic                     fir_done;
   logic signed [FILT_W-1:0] fir_result;
   logic [PER_W-1:0]         ring_q;

   assign accept = req_valid && !req_stall;

   pams_ram #(.WIDTH(PER_W), .DEPTH(PERIOD_SAMPLES)) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (head_ff),
      .wr_data ({half_ff, 1'b0}),
      .rd_en   (ring_rd),
      .rd_addr (rd_idx_ff[RING_AW-1:0]),
      .rd_data (ring_q)
   );

   pams_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   pams_fir u_fir (
      .clock  (clock),
      .reset  (reset),
      .req    (fir_req),
      .taps   (taps_ff),
      .done   (fir_done),
      .result (fir_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_PERIOD && req_half_period_cycles != '0) begin
               state_in = ST_RING_WR;
            end
         end
         ST_RING_WR:   state_in = ST_SUM;
         ST_SUM:       if (rd_idx_ff + 1'b1 == fill_ff) state_in = ST_SUM_END;
         ST_SUM_END:   state_in = ST_MUL_N;
         ST_MUL_N:     state_in = ST_MUL_F;
         ST_MUL_F:     state_in = ST_MUL_R;
         ST_MUL_R:     state_in = ST_MUL_D;
         ST_MUL_D:     state_in = ST_DIVF_GO;
         ST_DIVF_GO:   state_in = ST_DIVF_WAIT;
         ST_DIVF_WAIT: if (div_stat.done) state_in = ST_DIVR_GO;
         ST_DIVR_GO:   state_in = (ppr_ff == '0) ? ST_FIR_GO : ST_DIVR_WAIT;
         ST_DIVR_WAIT: if (div_stat.done) state_in = ST_FIR_GO;
         ST_FIR_GO:    state_in = ST_FIR_WAIT;
         ST_FIR_WAIT:  if (fir_done) state_in = ST_RESULT;
         ST_RESULT:    if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // strobes
   always_comb begin
      req_stall          = (state_ff != ST_IDLE);
      ring_wr            = (state_ff == ST_RING_WR);
      ring_rd            = (state_ff == ST_SUM);
      rsp_load           = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);
      div_start          = (state_ff == ST_DIVF_GO) ||
                           (state_ff == ST_DIVR_GO && ppr_ff != '0);
      div_num            = (state_ff == ST_DIVF_GO) ? NUM_W'(numf_ff) : numr_ff;
      div_den            = (state_ff == ST_DIVF_GO) ? DEN_W'(sum_ff) : denr_ff;
      fir_req.run        = (state_ff == ST_FIR_GO);
      fir_req.rpm        = rpm_ff;
      fir_req.coef_wr    = accept && req_func == FUNC_COEF &&
                           ({1'b0, req_coef_index} < (COEF_IDX_W+1)'(MAX_TAPS));
      fir_req.coef_index = req_coef_index;
      fir_req.coef_value = req_coef_value;
   end

   // datapath
   always_comb begin
      clk_in     = clk_ff;
      ppr_in     = ppr_ff;
      taps_in    = taps_ff;
      head_in    = head_ff;
      fill_in    = fill_ff;
      rd_idx_in  = rd_idx_ff;
      rd_pend_in = ring_rd;
      half_in    = accept ? req_half_period_cycles : half_ff;
      sum_in     = sum_ff;
      cn_in      = cn_ff;
      numf_in    = numf_ff;
      numr_in    = numr_ff;
      denr_in    = denr_ff;
      freq_in    = freq_ff;
      rpm_in     = rpm_ff;
      filt_in    = filt_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CLOCK_HZ: clk_in  = csr_data;
            CSR_PPR:      ppr_in  = csr_data[PPR_W-1:0];
            CSR_TAPS:     taps_in = csr_data[TAPS_W-1:0];
            default: ;
         endcase
      end
      case (state_ff)
         ST_RING_WR: begin
            head_in   = (head_ff == RING_AW'(PERIOD_SAMPLES - 1)) ? '0 : head_ff + 1'b1;
            if (fill_ff < FILL_W'(PERIOD_SAMPLES)) begin
               fill_in = fill_ff + 1'b1;
            end
            rd_idx_in = '0;
            sum_in    = '0;
         end
         ST_SUM:   rd_idx_in = rd_idx_ff + 1'b1;
         ST_MUL_N: cn_in     = CN_W'(clk_ff) * CN_W'(fill_ff);
         ST_MUL_F: numf_in   = NUMF_W'(cn_ff) * NUMF_W'(FREQ_SCALE);
         ST_MUL_R: numr_in   = NUM_W'(cn_ff) * NUM_W'(RPM_SCALE);
         ST_MUL_D: denr_in   = DEN_W'(sum_ff) * DEN_W'(ppr_ff);
         ST_DIVF_WAIT: begin
            if (div_stat.done) begin
               freq_in = (div_quot > NUM_W'({FREQ_W{1'b1}})) ? {FREQ_W{1'b1}}
                                                             : div_quot[FREQ_W-1:0];
            end
         end
         ST_DIVR_GO: if (ppr_ff == '0) rpm_in = '0;
         ST_DIVR_WAIT: begin
            if (div_stat.done) begin
               rpm_in = (div_quot > NUM_W'({RPM_W{1'b1}})) ? {RPM_W{1'b1}}
                                                           : div_quot[RPM_W-1:0];
            end
         end
         ST_FIR_WAIT: if (fir_done) filt_in = fir_result;
         default: ;
      endcase
      if (rd_pend_ff) begin
         sum_in = sum_ff + SUM_W'(ring_q);
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_ff       <= CLOCK_HZ_RST;
         ppr_ff       <= PPR_RST;
         taps_ff      <= TAPS_RST;
         head_ff      <= '0;
         fill_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_ff       <= clk_in;
         ppr_ff       <= ppr_in;
         taps_ff      <= taps_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      half_ff   <= half_in;
      sum_ff    <= sum_in;
      cn_ff     <= cn_in;
      numf_ff   <= numf_in;
      numr_ff   <= numr_in;
      denr_ff   <= denr_in;
      freq_ff   <= freq_in;
      rpm_ff    <= rpm_in;
      filt_ff   <= filt_in;
      if (rsp_load) begin
         rsp_freq_ff <= freq_ff;
         rsp_rpm_ff  <= rpm_ff;
         rsp_filt_ff <= filt_ff;
         rsp_avg_ff  <= AVG_W'(fill_ff);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_freq_millihertz    = rsp_freq_ff;
   assign rsp_rpm_raw_milli      = rsp_rpm_ff;
   assign rsp_rpm_filtered_milli = rsp_filt_ff;
   assign rsp_samples_averaged   = rsp_avg_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(PERIOD_SAMPLES))
      else $error("ring fill beyond ring depth");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a pending transaction");
   a_sum_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVF_GO) |-> (sum_ff != '0 && fill_ff != '0))
      else $error("average taken over an empty ring");
endmodule

// File: sim/period_average_speed_meter_tb.sv
// Self-checking testbench for period_average_speed_meter: predicts frequency,
// raw and filtered rpm per period sample. Depends on pams_pkg and the RTL.
module period_average_speed_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pams_pkg::*;

   typedef struct {
      logic              func;
      logic [HALF_W-1:0] half;
      logic [4:0]        cidx;
      logic [15:0]       cval;
   } meter_item_type;

   typedef struct {
      logic [FREQ_W-1:0] freq;
      logic [RPM_W-1:0]  rpm;
      logic [FILT_W-1:0] filt;
      logic [AVG_W-1:0]  avg;
   } speed_result_type;

   localparam int IDLE_WAIT = 400;
   localparam int WATCHDOG  = 20000;
   localparam int HOLD_LEN  = 3000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_func = 0;
   logic [HALF_W-1:0] req_half_period_cycles = '0;
   logic [4:0] req_coef_index = '0;
   logic signed [15:0] req_coef_value = '0;
   logic req_stall, rsp_valid;
   logic rsp_stall = 0;
   logic [FREQ_W-1:0] rsp_freq_millihertz;
   logic [RPM_W-1:0] rsp_rpm_raw_milli;
   logic signed [FILT_W-1:0] rsp_rpm_filtered_milli;
   logic [AVG_W-1:0] rsp_samples_averaged;
   logic csr_write = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CLK_W-1:0] csr_data = '0;

   period_average_speed_meter dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // predictor state
   longint unsigned clk_hz = 125000000, ppr = 20, taps = 1;
   longint unsigned ring [PERIOD_SAMPLES];
   int head = 0, fill = 0, dptr = 0;
   longint coefs [MAX_TAPS];
   longint unsigned dline [MAX_TAPS];

   meter_item_type   pending_items[$];
   speed_result_type expected_speeds[$];
   int errors = 0, mismatches = 0, idle_cycles = 0;
   int stall_left = 0, hold_cycles = 0;
   bit hold_rsp = 0, hold_armed = 0, hold_done = 0;

   function automatic void predict_item(meter_item_type it);
      longint unsigned sum, n, fr, rp, num;
      longint hi, lo, prod, res;
      int tk, idx;
      speed_result_type r;
      if (it.func == FUNC_COEF) begin
         coefs[it.cidx] = longint'($signed(it.cval));
         return;
      end
      if (it.half == 0) return;
      ring[head] = longint'(it.half) * 2;
      head = (head + 1) % PERIOD_SAMPLES;
      if (fill < PERIOD_SAMPLES) fill++;
      n = fill; sum = 0; fr = 0; rp = 0;
      for (int i = 0; i < fill; i++) sum += ring[i];
      fr = clk_hz * 1000 * n / sum;
      if (ppr != 0) begin
         // clk*60000*n fits 64 bits; sum*ppr fits too
         num = clk_hz * 60000 * n;
         rp = num / (sum * ppr);
      end
      if (fr > (64'd1 << 37) - 1) fr = (64'd1 << 37) - 1;
      if (rp > (64'd1 << 43) - 1) rp = (64'd1 << 43) - 1;
      dline[dptr] = rp;
      tk = (taps > MAX_TAPS) ? MAX_TAPS : int'(taps);
      res = 0;
      if (tk != 0) begin
         hi = 0; lo = 16384;
         for (int k = 0; k < tk; k++) begin
            idx = (dptr + MAX_TAPS - k) % MAX_TAPS;
            prod = coefs[k] * longint'(dline[idx]);
            hi += prod >>> 15;
            lo += prod & 64'h7FFF;
         end
         res = hi + (lo >>> 15);
         if (res > (64'sd1 <<< 47) - 1) res = (64'sd1 <<< 47) - 1;
         if (res < -(64'sd1 <<< 47)) res = -(64'sd1 <<< 47);
      end
      dptr = (dptr + 1) % MAX_TAPS;
      r.freq = fr[FREQ_W-1:0];
      r.rpm  = rp[RPM_W-1:0];
      r.filt = res[FILT_W-1:0];
      r.avg  = n[3:0];
      expected_speeds.push_back(r);
   endfunction

   // driver; the front of the queue is the transaction on the bus
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            predict_item(pending_items.pop_front());
         end
         if (gap > 0) begin
            gap--;
            req_valid <= 0;
         end else if (pending_items.size() != 0) begin
            meter_item_type nx;
            nx = pending_items[0];
            req_valid <= 1;
            req_func <= nx.func;
            req_half_period_cycles <= nx.half;
            req_coef_index <= nx.cidx;
            req_coef_value <= nx.cval;
            gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 20) == 0) ?
                  $urandom_range(20, 200) : $urandom_range(1, 4)) : 0;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_rsp) begin
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles == HOLD_LEN - 1) begin
            hold_rsp  <= 0;
            hold_done <= 1;
         end
      end else if (hold_armed && !hold_done) begin
         hold_rsp <= 1;
      end
   end

   // receiver stall and monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_speeds.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected transaction");
            end else begin
               speed_result_type e;
               e = expected_speeds.pop_front();
               if (e.freq !== rsp_freq_millihertz || e.rpm !== rsp_rpm_raw_milli ||
                   e.filt !== rsp_rpm_filtered_milli || e.avg !== rsp_samples_averaged) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                        e.freq, e.rpm, $signed(e.filt), e.avg, rsp_freq_millihertz,
                        rsp_rpm_raw_milli, rsp_rpm_filtered_milli, rsp_samples_averaged);
               end
            end
         end
         if (hold_rsp) begin
            rsp_stall <= 1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150)
                                                       : $urandom_range(0, 2);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_rsp)
         idle_cycles <= 0;
      else if (pending_items.size() != 0 || expected_speeds.size() != 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_wr(logic [CSR_IDX_W-1:0] idx, longint unsigned v);
      @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= CLK_W'(v);
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_CLOCK_HZ: clk_hz = v & 28'hFFFFFFF;
         CSR_PPR:      ppr = v & 16'hFFFF;
         CSR_TAPS:     taps = v & 6'h3F;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_speeds.size() != 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   function automatic meter_item_type mk(logic f, logic [HALF_W-1:0] h,
                                         logic [4:0] ci, logic [15:0] cv);
      meter_item_type it;
      it.func = f; it.half = h; it.cidx = ci; it.cval = cv;
      return it;
   endfunction

   function automatic logic [HALF_W-1:0] rand_half();
      case ($urandom_range(0, 5))
         0: return HALF_W'($urandom_range(1, 20));
         1: return HALF_W'({$urandom, $urandom});
         2: return 31'h7FFFFFFF - HALF_W'($urandom_range(0, 3));
         default: return HALF_W'($urandom_range(100, 2000000));
      endcase
   endfunction

   task automatic random_phase(int cnt);
      for (int i = 0; i < cnt; i++) begin
         int r;
         r = $urandom_range(0, 19);
         if (r == 0)
            pending_items.push_back(mk(FUNC_PERIOD, '0, 5'($urandom), 16'($urandom)));
         else if (r < 3)
            pending_items.push_back(mk(FUNC_COEF, HALF_W'($urandom), 5'($urandom),
                                       16'($urandom)));
         else
            pending_items.push_back(mk(FUNC_PERIOD, rand_half(), 5'($urandom),
                                       16'($urandom)));
      end
   endtask

   initial begin
      foreach (ring[i]) ring[i] = 0;
      foreach (coefs[i]) begin coefs[i] = 0; dline[i] = 0; end
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed: zero period, coefficient extremes, period extremes
      pending_items.push_back(mk(FUNC_PERIOD, '0, '0, '0));
      pending_items.push_back(mk(FUNC_PERIOD, HALF_W'(1), '0, '0));
      pending_items.push_back(mk(FUNC_COEF, '0, '0, 16'h7FFF));
      pending_items.push_back(mk(FUNC_COEF, HALF_W'(1), 5'd1, 16'h8000));
      pending_items.push_back(mk(FUNC_COEF, '0, 5'd31, 16'hFFFF));
      pending_items.push_back(mk(FUNC_PERIOD, 31'h7FFFFFFF, 5'd31, 16'hFFFF));
      for (int i = 0; i < 9; i++)
         pending_items.push_back(mk(FUNC_PERIOD, HALF_W'(i + 1), '0, '0));
      drain();
      csr_wr(CSR_TAPS, 0);
      csr_wr(CSR_PPR, 0);
      csr_wr(CSR_CLOCK_HZ, 200000000);
      pending_items.push_back(mk(FUNC_PERIOD, HALF_W'(1), '0, '0));
      pending_items.push_back(mk(FUNC_PERIOD, HALF_W'(7), '0, '0));
      drain();
      csr_wr(CSR_CLOCK_HZ, 0);
      csr_wr(CSR_PPR, 65535);
      csr_wr(CSR_TAPS, 63);
      pending_items.push_back(mk(FUNC_PERIOD, HALF_W'(3), '0, '0));
      drain();
      csr_wr(CSR_CLOCK_HZ, 28'hFFFFFFF);
      csr_wr(CSR_PPR, 1);
      csr_wr(CSR_TAPS, 32);
      for (int i = 0; i < 32; i++)
         pending_items.push_back(mk(FUNC_COEF, '0, 5'(i), 16'($urandom)));
      random_phase(150);
      // long receiver hold-off while the sender keeps offering
      repeat (50) @(posedge clock);
      hold_armed = 1;
      wait (hold_done);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         csr_wr(CSR_CLOCK_HZ, $urandom_range(1, 200000000));
         csr_wr(CSR_PPR, $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 65535));
         csr_wr(CSR_TAPS, $urandom_range(0, 5) == 0 ? $urandom_range(0, 63) :
                          $urandom_range(1, 32));
         random_phase(150);
         drain();
      end
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
